@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ hdl/pcbs_pkg.sv @@
// Package for the pseudocost branch selector: payload structs, codes, constants.
// Depends on nothing.
package pcbs_pkg;
	localparam int FB = 16;
	localparam logic [39:0] QSAT = 40'hFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		CFG_TOL = 2'd0,
		CFG_MU = 2'd1,
		CFG_MODE = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVD,
		ST_DIVU,
		ST_MULD,
		ST_MULU,
		ST_WLO,
		ST_WHI,
		ST_SCORE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [47:0] relax_value;
		logic is_integer_col;
		logic [39:0] down_cost_sum;
		logic [39:0] up_cost_sum;
		logic [15:0] down_count;
		logic [15:0] up_count;
		logic last_col;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [15:0] best_column;
		logic [47:0] best_score;
		logic signed [31:0] floor_bound;
		logic signed [31:0] ceil_bound;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [39:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [39:0] quotient;
	} div_rsp_t;
endpackage

@@ hdl/pseudocost_branch_select.sv @@
// Top level of the pseudocost branch selector: sequencer, argmax state, output register.
// Depends on pcbs_pkg, pcbs_div, pcbs_mul and assert_macros.svh.
//
// channel | direction | handshake           | payload
// in      | in        | in_valid / in_ready | in_item_t
// out     | out       | out_valid/out_ready | out_item_t
// cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// An unscored column passes the accept, score-check and output states before the next
// acceptance; a scored column also runs two bit-serial divides and four shift-add
// multiplies (two side costs, two score weights) between the score check and output.
// The last column also waits until the previous result has left the output register.
// Reset clears control, the argmax state and the configuration to defaults.
`include "assert_macros.svh"
module pseudocost_branch_select import pcbs_pkg::*; #(
	parameter int MAX_COLUMNS = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [15:0] tol_q, mu_q;
	logic mode_q;
	logic [CW-1:0] col_q;
	logic [48:0] best_q;
	logic [15:0] bidx_q;
	logic signed [47:0] bval_q;
	logic found_q;
	logic [39:0] qd_q, qu_q;
	logic [39:0] pd_q;
	logic [39:0] hi_q;
	logic [56:0] wlo_q;
	logic [16:0] fdown, fup, near_dist;
	logic scoring;
	div_req_t dreq;
	div_rsp_t drsp;
	logic mstart, mdone;
	logic [39:0] mcand;
	logic [16:0] mplier;
	logic [56:0] prod;
	logic [39:0] pcur;
	logic [39:0] lo, hi;
	logic [57:0] wsum;
	logic [48:0] score, best_now;
	logic beats;
	logic signed [48:0] fl, ce;
	logic signed [31:0] fl32, ce32;

	assign fdown = {1'b0, item_q.relax_value[FB-1:0]};
	assign fup = (fdown == 17'd0) ? 17'd0 : 17'h10000 - fdown;
	assign near_dist = (fdown < fup) ? fdown : fup;
	assign scoring = item_q.is_integer_col && (near_dist > {1'b0, tol_q});

	assign pcur = prod[FB+39:FB];
	assign lo = (pd_q < pcur) ? pd_q : pcur;
	assign hi = (pd_q < pcur) ? pcur : pd_q;
	// The two weighted products are summed in full before the fraction is dropped.
	assign wsum = {1'b0, wlo_q} + {1'b0, prod};
	assign score = {7'd0, wsum[57:FB]};
	assign best_now = found_q ? best_q : (mode_q ? 49'd0 : -49'sd65536);
	assign beats = $signed(score) > $signed(best_now);

	pcbs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	pcbs_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mstart), .mcand(mcand),
		.mplier(mplier), .done(mdone), .prod(prod));

	assign fl = $signed({bval_q[47], bval_q}) >>> FB;
	assign ce = fl + ((bval_q[FB-1:0] != '0) ? 49'sd1 : 49'sd0);
	assign fl32 = (fl > 49'sd2147483647) ? 32'sh7FFFFFFF :
		(fl < -49'sd2147483648) ? 32'sh80000000 : fl[31:0];
	assign ce32 = (ce > 49'sd2147483647) ? 32'sh7FFFFFFF :
		(ce < -49'sd2147483648) ? 32'sh80000000 : ce[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		dreq = '{start: 1'b0, dividend: item_q.down_cost_sum, divisor: item_q.down_count};
		mstart = 1'b0;
		mcand = qd_q;
		mplier = fdown;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_SCORE;
			end
			ST_SCORE: begin
				if (scoring) begin
					dreq.start = 1'b1;
					state_d = ST_DIVD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIVD: begin
				if (drsp.done) begin
					dreq = '{start: 1'b1, dividend: item_q.up_cost_sum,
						divisor: item_q.up_count};
					state_d = ST_DIVU;
				end
			end
			ST_DIVU: begin
				if (drsp.done) begin
					mstart = 1'b1;
					state_d = ST_MULD;
				end
			end
			ST_MULD: begin
				mcand = qu_q;
				mplier = fup;
				if (mdone) begin
					mstart = 1'b1;
					state_d = ST_MULU;
				end
			end
			ST_MULU: begin
				// The smaller side cost gets the weight 1 - mu.
				mcand = lo;
				mplier = 17'h10000 - {1'b0, mu_q};
				if (mdone) begin
					mstart = 1'b1;
					state_d = ST_WLO;
				end
			end
			ST_WLO: begin
				mcand = hi_q;
				mplier = {1'b0, mu_q};
				if (mdone) begin
					mstart = 1'b1;
					state_d = ST_WHI;
				end
			end
			ST_WHI: begin
				if (mdone) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!item_q.last_col || !out_valid || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
		if (state_q == ST_DIVD && drsp.done) qd_q <= drsp.quotient;
		if (state_q == ST_DIVU && drsp.done) qu_q <= drsp.quotient;
		if (state_q == ST_MULD && mdone) pd_q <= pcur;
		if (state_q == ST_MULU && mdone) hi_q <= hi;
		if (state_q == ST_WLO && mdone) wlo_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd66;
			mu_q <= 16'd10923;
			mode_q <= 1'b0;
			col_q <= '0;
			best_q <= -49'sd65536;
			bidx_q <= '0;
			bval_q <= '0;
			found_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TOL: tol_q <= cfg_data;
					CFG_MU: mu_q <= cfg_data;
					CFG_MODE: mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_WHI && mdone && beats) begin
				best_q <= score;
				bidx_q <= 16'(col_q);
				bval_q <= item_q.relax_value;
				found_q <= 1'b1;
			end
			if (state_q == ST_OUT && state_d == ST_IDLE && item_q.last_col) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (state_q == ST_OUT && state_d == ST_IDLE) begin
				if (item_q.last_col) begin
					out_data.found <= found_q;
					out_data.best_column <= found_q ? bidx_q : 16'd0;
					out_data.best_score <= found_q ? best_q[47:0] : 48'd0;
					out_data.floor_bound <= found_q ? fl32 : 32'sd0;
					out_data.ceil_bound <= found_q ? ce32 : 32'sd0;
					col_q <= '0;
					found_q <= 1'b0;
					bidx_q <= '0;
					bval_q <= '0;
				end else begin
					col_q <= (col_q == CW'(MAX_COLUMNS - 1)) ? '0 : col_q + 1'b1;
				end
			end
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`ASSERT_IMPL(a_no_overrun, clk, arst_n, state_q == ST_OUT && item_q.last_col && out_valid && !out_ready, state_d == ST_OUT)
	`ASSERT_NEXT(a_clear, clk, arst_n, state_q == ST_OUT && state_d == ST_IDLE && item_q.last_col, !found_q && out_valid)
endmodule

@@ hdl/pcbs_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pcbs_pkg and assert_macros.svh; zero divisor saturates the quotient.
`include "assert_macros.svh"
module pcbs_div import pcbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic [39:0] num_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic zero_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], num_q[39]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd40;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			zero_q <= (req.divisor == 16'd0);
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				num_q <= {num_q[38:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[38:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quotient: (zero_q ? QSAT : num_q)};

	`ASSERT_NEXT(a_div_busy, clk, arst_n, req.start, busy_q)
	`ASSERT_IMPL(a_div_done, clk, arst_n, done_q, !busy_q)
	`ASSERT_IMPL(a_div_cnt, clk, arst_n, busy_q, cnt_q != 6'd0)
endmodule

@@ hdl/pcbs_mul.sv @@
// Shift-add multiplier: 40-bit quotient times 17-bit fraction, one bit per cycle.
// Depends on pcbs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcbs_mul import pcbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [39:0] mcand,
	input logic [16:0] mplier,
	output logic done,
	output logic [56:0] prod
);
	logic [16:0] mp_q;
	logic [56:0] acc_q;
	logic [56:0] mc_q;
	logic [4:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mp_q <= mplier;
			mc_q <= {17'd0, mcand};
			acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mp_q <= {1'b0, mp_q[16:1]};
			mc_q <= {mc_q[55:0], 1'b0};
		end
	end

	assign prod = acc_q;

	`ASSERT_NEXT(a_mul_busy, clk, arst_n, start, busy_q)
	`ASSERT_IMPL(a_mul_done, clk, arst_n, done, !busy_q)
	`ASSERT_IMPL(a_mul_cnt, clk, arst_n, busy_q, cnt_q != 5'd0)
endmodule
